// ===== src/proof_language_tokenizer_assert.svh =====
// assertion macros for the tokenizer modules, included by ptok_back
`ifndef PROOF_LANGUAGE_TOKENIZER_ASSERT_SVH
`define PROOF_LANGUAGE_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PLT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tokenizer assertion failed");
`define PLT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tokenizer assertion failed");
`else
`define PLT_ASSERT(lbl, prop)
`define PLT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/ptok_pkg.sv =====
package ptok_pkg;

   localparam int LINE_BITS   = 16;
   localparam int COL_BITS    = 16;
   localparam int MATCH_LEN   = 8;
   localparam int LOOKAHEAD   = 4;
   localparam int FILL_BITS   = $clog2(LOOKAHEAD + 1);
   localparam int IDX_BITS    = $clog2(LOOKAHEAD);
   localparam int WLEN_BITS   = $clog2(MATCH_LEN + 2);
   localparam int KEY_BITS    = 8 * MATCH_LEN;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [5:0] K_EOF     = 6'd0;
   localparam logic [5:0] K_INDENT  = 6'd1;
   localparam logic [5:0] K_STRING  = 6'd2;
   localparam logic [5:0] K_LITERAL = 6'd3;
   localparam logic [5:0] K_IDENT   = 6'd4;
   localparam logic [5:0] K_DELIM   = 6'd5;
   localparam logic [5:0] K_COMMA   = 6'd6;
   localparam logic [5:0] K_WORD0   = 6'd7;
   localparam logic [5:0] K_FORALL  = 6'd11;
   localparam logic [5:0] K_EXISTS  = 6'd12;
   localparam logic [5:0] K_IN      = 6'd13;
   localparam logic [5:0] K_OP0     = 6'd36;
   localparam logic [5:0] K_UNKNOWN = 6'd44;

   // record kinds
   localparam logic RK_VALUE = 1'b0;
   localparam logic RK_TOKEN = 1'b1;

   // characters with a role of their own
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_COMMA  = 8'd44;
   localparam logic [7:0] CH_DOT    = 8'd46;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_UNDER  = 8'd95;
   localparam logic [7:0] CH_LOW_N  = 8'd110;
   localparam logic [7:0] CH_LOW_T  = 8'd116;

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_STR, M_ESC, M_INT, M_FRAC, M_IDENT, M_BSLASH, M_QUANT, M_OP
   } scan_mode_type;

   typedef enum logic [2:0] {
      S_WAIT, S_DRAIN, S_INDENT, S_SEC, S_FIN, S_EOF, S_LAST
   } seq_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic       rk;
      logic [7:0] val;
      logic [5:0] kind;
   } rec_type;

   typedef struct packed {
      logic        rk;
      logic [7:0]  val;
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic        last;
   } result_type;

   // keys are right aligned, first character in the highest used byte
   localparam logic [KEY_BITS-1:0] WORD_TBL [29] = '{
      KEY_BITS'("theorem"), KEY_BITS'("axiom"), KEY_BITS'("qed"), KEY_BITS'("sorry"),
      KEY_BITS'("forall"), KEY_BITS'("exists"), KEY_BITS'("in"), KEY_BITS'("id"),
      KEY_BITS'("cut"), KEY_BITS'("andL1"), KEY_BITS'("andL2"), KEY_BITS'("orL"),
      KEY_BITS'("implL"), KEY_BITS'("notL"), KEY_BITS'("forallL"), KEY_BITS'("existL"),
      KEY_BITS'("wl"), KEY_BITS'("cl"), KEY_BITS'("pl"), KEY_BITS'("orR1"),
      KEY_BITS'("orR2"), KEY_BITS'("andR"), KEY_BITS'("implR"), KEY_BITS'("notR"),
      KEY_BITS'("forallR"), KEY_BITS'("existR"), KEY_BITS'("wr"), KEY_BITS'("cr"),
      KEY_BITS'("pr")};

   localparam logic [KEY_BITS-1:0] OP_TBL [8] = '{
      KEY_BITS'("\\/"), KEY_BITS'("/\\"), KEY_BITS'("->"), KEY_BITS'("~"),
      KEY_BITS'("="), KEY_BITS'(":="), KEY_BITS'("<=>"), KEY_BITS'("|-")};

   localparam logic [KEY_BITS-1:0] KEY_FORALL = KEY_BITS'("\\forall");
   localparam logic [KEY_BITS-1:0] KEY_EXISTS = KEY_BITS'("\\exists");
   localparam logic [KEY_BITS-1:0] KEY_IN     = KEY_BITS'("\\in");

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c inside {"(", ")", "[", "]", "{", "}", ",", ";", "."};
   endfunction

   function automatic logic is_opch(input logic [7:0] c);
      return c inside {"+", "-", "*", "/", "=", "<", ">", "!", "&", "|", "~", "^", "\\", ":"};
   endfunction

   function automatic logic [5:0] word_kind(input logic [KEY_BITS-1:0] key,
                                            input logic [WLEN_BITS-1:0] wlen);
      logic [5:0] kind;
      kind = K_IDENT;
      for (int i = 28; i >= 0; i--) begin
         if (wlen <= WLEN_BITS'(MATCH_LEN) && key == WORD_TBL[i]) kind = K_WORD0 + 6'(i);
      end
      return kind;
   endfunction

   function automatic logic [5:0] op_kind(input logic [KEY_BITS-1:0] key,
                                          input logic [WLEN_BITS-1:0] wlen);
      logic [5:0] kind;
      kind = K_UNKNOWN;
      for (int i = 7; i >= 0; i--) begin
         if (wlen <= WLEN_BITS'(MATCH_LEN) && key == OP_TBL[i]) kind = K_OP0 + 6'(i);
      end
      return kind;
   endfunction

   // zero when the word is no quantifier
   function automatic logic [5:0] quant_kind(input logic [KEY_BITS-1:0] key,
                                             input logic [WLEN_BITS-1:0] wlen);
      logic ok;
      ok = wlen <= WLEN_BITS'(MATCH_LEN);
      if (ok && key == KEY_FORALL) return K_FORALL;
      if (ok && key == KEY_EXISTS) return K_EXISTS;
      if (ok && key == KEY_IN) return K_IN;
      return K_EOF;
   endfunction

endpackage

// ===== src/ptok_front.sv =====
module ptok_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_ch,
   input  logic                    req_end_of_input,
   output ptok_pkg::queue_head_type head,
   input  logic                    head_pop
);
   import ptok_pkg::*;

   item_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push, pop;
   item_type             incoming;

   // the end mark carries no byte
   always_comb begin
      incoming.eoi = req_end_of_input;
      incoming.ch  = req_end_of_input ? 8'd0 : req_ch;
   end

   assign req_stall  = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign push       = req_valid && !req_stall;
   assign pop        = head_pop && head.valid;
   assign head.valid = count_ff != '0;
   assign head.item  = entries_ff[rd_ff];

   always_comb begin
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ff] <= incoming;
   end

endmodule

// ===== src/ptok_back.sv =====
`include "proof_language_tokenizer_assert.svh"
module ptok_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ptok_pkg::queue_head_type head,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_record_kind,
   output logic [7:0]              rsp_value_char,
   output logic [5:0]              rsp_token_kind,
   output logic [15:0]             rsp_start_line,
   output logic [15:0]             rsp_start_col,
   output logic                    rsp_last_of_run
);
   import ptok_pkg::*;

   seq_state_type        seq_ff, seq_in, ret_ff, ret_in;
   scan_mode_type        mode_ff, mode_in;
   logic [LINE_BITS-1:0] line_ff, line_in, tok_line_ff, tok_line_in, line_inc;
   logic [COL_BITS-1:0]  col_ff, col_in, tok_col_ff, tok_col_in, col_inc;
   logic [7:0]           buf_ff [LOOKAHEAD];
   logic [7:0]           buf_in [LOOKAHEAD];
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [KEY_BITS-1:0]  key_ff, key_in, base_key;
   logic [WLEN_BITS-1:0] wlen_ff, wlen_in, base_len;
   logic                 eoi_ff, eoi_in;
   logic [2:0]           cnt_ff, cnt_in;
   rec_type              sec_ff, sec_in, em;
   logic                 em_en, mv_en, shift1, wadd, tok_begin, pop, flush, advance;
   logic [2:0]           need;
   logic [7:0]           c, n1;
   logic                 n1_ok, col1, indent_hit;
   logic [5:0]           qk, ok_kind;
   logic [LINE_BITS-1:0] em_line;
   logic [COL_BITS-1:0]  em_col;
   result_type           hold_ff, out_ff;
   logic                 hold_v_ff, out_v_ff;

   assign c     = buf_ff[0];
   assign n1    = buf_ff[1];
   assign n1_ok = fill_ff > FILL_BITS'(1);
   assign col1  = col_ff == COL_BITS'(1);
   assign qk      = quant_kind(key_ff, wlen_ff);
   assign ok_kind = op_kind(key_ff, wlen_ff);
   assign indent_hit = (c == CH_SPACE) && col1 && n1_ok && (n1 == CH_SPACE)
                    && (fill_ff > FILL_BITS'(2)) && (buf_ff[2] == CH_SPACE)
                    && (fill_ff > FILL_BITS'(3)) && (buf_ff[3] == CH_SPACE);
   assign line_inc = (line_ff != '1) ? line_ff + 1'b1 : line_ff;
   assign col_inc  = (col_ff != '1) ? col_ff + 1'b1 : col_ff;

   // room to hand a result on, else the whole sequencer holds
   assign advance  = !hold_v_ff || !out_v_ff || !rsp_stall;
   assign head_pop = pop && advance;

   always_comb begin
      need = 3'd1;
      if (mode_ff == M_IDLE) begin
         if (c == CH_SPACE && col1) need = 3'd4;
         else if (c == CH_SLASH || c == CH_DOT) need = 3'd2;
      end
      if (mode_ff == M_INT && c == CH_DOT) need = 3'd2;
   end

   always_comb begin
      seq_in      = seq_ff;
      ret_in      = ret_ff;
      mode_in     = mode_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      buf_in      = buf_ff;
      fill_in     = fill_ff;
      key_in      = key_ff;
      wlen_in     = wlen_ff;
      eoi_in      = eoi_ff;
      cnt_in      = cnt_ff;
      sec_in      = sec_ff;
      em_en       = 1'b0;
      em          = '{rk: RK_VALUE, val: c, kind: K_EOF};
      mv_en       = 1'b0;
      shift1      = 1'b0;
      wadd        = 1'b0;
      tok_begin   = 1'b0;
      pop         = 1'b0;
      flush       = 1'b0;
      base_key    = key_ff;
      base_len    = wlen_ff;

      case (seq_ff)
         S_WAIT: begin
            if (head.valid) begin
               pop    = 1'b1;
               eoi_in = head.item.eoi;
               if (!head.item.eoi && fill_ff < FILL_BITS'(LOOKAHEAD)) begin
                  buf_in[fill_ff[IDX_BITS-1:0]] = head.item.ch;
                  fill_in = fill_ff + 1'b1;
               end
               seq_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (fill_ff == '0 || (!eoi_ff && fill_ff < FILL_BITS'(need))) begin
               seq_in = eoi_ff ? S_FIN : S_LAST;
            end else begin
               case (mode_ff)
                  M_IDLE: begin
                     tok_begin = 1'b1;
                     if (indent_hit) begin
                        cnt_in = 3'd0;
                        seq_in = S_INDENT;
                     end else begin
                        shift1 = 1'b1;
                        mv_en  = 1'b1;
                        if (is_space(c)) begin
                        end else if (c == CH_SLASH && n1_ok && n1 == CH_SLASH) begin
                           mode_in = M_COMMENT;
                        end else if (c == CH_QUOTE) begin
                           mode_in = M_STR;
                        end else if (is_digit(c) || (c == CH_DOT && n1_ok && is_digit(n1))) begin
                           em_en   = 1'b1;
                           mode_in = is_digit(c) ? M_INT : M_FRAC;
                        end else if (is_alpha(c) || c == CH_UNDER) begin
                           em_en   = 1'b1;
                           wadd    = 1'b1;
                           mode_in = M_IDENT;
                        end else begin
                           em_en = 1'b1;
                           if (is_opch(c)) begin
                              wadd    = 1'b1;
                              mode_in = (c == CH_BSLASH) ? M_BSLASH : M_OP;
                           end else begin
                              sec_in = '{rk: RK_TOKEN, val: 8'd0,
                                         kind: is_delim(c) ? ((c == CH_COMMA) ? K_COMMA : K_DELIM)
                                                           : K_UNKNOWN};
                              ret_in = S_DRAIN;
                              seq_in = S_SEC;
                           end
                        end
                     end
                  end
                  M_COMMENT: begin
                     if (c == CH_NL) begin
                        mode_in = M_IDLE;
                     end else begin
                        mv_en  = 1'b1;
                        shift1 = 1'b1;
                     end
                  end
                  M_STR: begin
                     mv_en  = 1'b1;
                     shift1 = 1'b1;
                     if (c == CH_QUOTE) begin
                        em_en   = 1'b1;
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: K_STRING};
                        mode_in = M_IDLE;
                     end else if (c == CH_BSLASH) begin
                        mode_in = M_ESC;
                     end else begin
                        em_en = 1'b1;
                     end
                  end
                  M_ESC: begin
                     mv_en   = 1'b1;
                     shift1  = 1'b1;
                     em_en   = 1'b1;
                     mode_in = M_STR;
                     if (c == CH_LOW_N) begin
                        em.val = CH_NL;
                     end else if (c == CH_LOW_T) begin
                        em.val = CH_TAB;
                     end else if (c != CH_BSLASH && c != CH_QUOTE) begin
                        // unknown escape keeps the backslash and the byte
                        em.val = CH_BSLASH;
                        sec_in = '{rk: RK_VALUE, val: c, kind: K_EOF};
                        ret_in = S_DRAIN;
                        seq_in = S_SEC;
                     end
                  end
                  M_INT: begin
                     if (is_digit(c) || (c == CH_DOT && n1_ok && is_digit(n1))) begin
                        em_en  = 1'b1;
                        mv_en  = 1'b1;
                        shift1 = 1'b1;
                        if (!is_digit(c)) mode_in = M_FRAC;
                     end else begin
                        em_en   = 1'b1;
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: K_LITERAL};
                        mode_in = M_IDLE;
                     end
                  end
                  M_FRAC: begin
                     em_en = 1'b1;
                     if (is_digit(c)) begin
                        mv_en  = 1'b1;
                        shift1 = 1'b1;
                     end else begin
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: K_LITERAL};
                        mode_in = M_IDLE;
                     end
                  end
                  M_IDENT: begin
                     em_en = 1'b1;
                     if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                        wadd   = 1'b1;
                        mv_en  = 1'b1;
                        shift1 = 1'b1;
                     end else begin
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: word_kind(key_ff, wlen_ff)};
                        mode_in = M_IDLE;
                     end
                  end
                  M_BSLASH, M_QUANT: begin
                     if (is_alpha(c)) begin
                        em_en   = 1'b1;
                        wadd    = 1'b1;
                        mv_en   = 1'b1;
                        shift1  = 1'b1;
                        mode_in = M_QUANT;
                     end else if (mode_ff == M_QUANT && qk != K_EOF) begin
                        em_en   = 1'b1;
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: qk};
                        mode_in = M_IDLE;
                     end else begin
                        // not a quantifier: carry on as an operator run
                        mode_in = M_OP;
                     end
                  end
                  default: begin
                     em_en = 1'b1;
                     if (is_opch(c)) begin
                        wadd   = 1'b1;
                        mv_en  = 1'b1;
                        shift1 = 1'b1;
                     end else begin
                        em      = '{rk: RK_TOKEN, val: 8'd0, kind: ok_kind};
                        mode_in = M_IDLE;
                     end
                  end
               endcase
            end
         end
         S_INDENT: begin
            em_en = 1'b1;
            if (cnt_ff < 3'd4) begin
               em     = '{rk: RK_VALUE, val: CH_SPACE, kind: K_EOF};
               mv_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               em      = '{rk: RK_TOKEN, val: 8'd0, kind: K_INDENT};
               mode_in = M_IDLE;
               fill_in = fill_ff - FILL_BITS'(4);
               for (int i = 0; i + 4 < LOOKAHEAD; i++) buf_in[i] = buf_ff[i + 4];
               seq_in  = S_DRAIN;
            end
         end
         S_SEC: begin
            em_en  = 1'b1;
            em     = sec_ff;
            seq_in = ret_ff;
         end
         S_FIN: begin
            mode_in = M_IDLE;
            seq_in  = S_EOF;
            em      = '{rk: RK_TOKEN, val: 8'd0, kind: K_STRING};
            case (mode_ff)
               M_ESC: begin
                  // trailing lone backslash stays in the value
                  em_en  = 1'b1;
                  em     = '{rk: RK_VALUE, val: CH_BSLASH, kind: K_EOF};
                  sec_in = '{rk: RK_TOKEN, val: 8'd0, kind: K_STRING};
                  ret_in = S_EOF;
                  seq_in = S_SEC;
               end
               M_STR: em_en = 1'b1;
               M_INT, M_FRAC: begin
                  em_en   = 1'b1;
                  em.kind = K_LITERAL;
               end
               M_IDENT: begin
                  em_en   = 1'b1;
                  em.kind = word_kind(key_ff, wlen_ff);
               end
               M_QUANT: begin
                  em_en   = 1'b1;
                  em.kind = (qk != K_EOF) ? qk : ok_kind;
               end
               M_BSLASH, M_OP: begin
                  em_en   = 1'b1;
                  em.kind = ok_kind;
               end
               default: em_en = 1'b0;
            endcase
         end
         S_EOF: begin
            em_en       = 1'b1;
            em          = '{rk: RK_TOKEN, val: 8'd0, kind: K_EOF};
            line_in     = LINE_BITS'(1);
            col_in      = COL_BITS'(1);
            tok_line_in = LINE_BITS'(1);
            tok_col_in  = COL_BITS'(1);
            fill_in     = '0;
            wlen_in     = '0;
            key_in      = '0;
            mode_in     = M_IDLE;
            seq_in      = S_LAST;
         end
         S_LAST: begin
            flush  = 1'b1;
            seq_in = S_WAIT;
         end
         default: seq_in = S_WAIT;
      endcase

      if (tok_begin) begin
         tok_line_in = line_ff;
         tok_col_in  = col_ff;
         wlen_in     = '0;
         key_in      = '0;
         base_key    = '0;
         base_len    = '0;
      end
      if (wadd) begin
         if (base_len < WLEN_BITS'(MATCH_LEN)) key_in = {base_key[KEY_BITS-9:0], c};
         if (base_len <= WLEN_BITS'(MATCH_LEN)) wlen_in = base_len + 1'b1;
      end
      if (mv_en) begin
         if (c == CH_NL) begin
            line_in = line_inc;
            col_in  = COL_BITS'(1);
         end else begin
            col_in = col_inc;
         end
      end
      if (shift1) begin
         for (int i = 0; i + 1 < LOOKAHEAD; i++) buf_in[i] = buf_ff[i + 1];
         fill_in = fill_ff - 1'b1;
      end
   end

   // positions: a new token starts at the current place, end of source reports it too
   always_comb begin
      if (seq_ff == S_EOF || tok_begin) begin
         em_line = line_ff;
         em_col  = col_ff;
      end else begin
         em_line = tok_line_ff;
         em_col  = tok_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= S_WAIT;
         ret_ff      <= S_DRAIN;
         mode_ff     <= M_IDLE;
         line_ff     <= LINE_BITS'(1);
         col_ff      <= COL_BITS'(1);
         tok_line_ff <= LINE_BITS'(1);
         tok_col_ff  <= COL_BITS'(1);
         fill_ff     <= '0;
         wlen_ff     <= '0;
         eoi_ff      <= 1'b0;
         cnt_ff      <= '0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         if (advance) begin
            seq_ff      <= seq_in;
            ret_ff      <= ret_in;
            mode_ff     <= mode_in;
            line_ff     <= line_in;
            col_ff      <= col_in;
            tok_line_ff <= tok_line_in;
            tok_col_ff  <= tok_col_in;
            fill_ff     <= fill_in;
            wlen_ff     <= wlen_in;
            eoi_ff      <= eoi_in;
            cnt_ff      <= cnt_in;
         end
         if (advance && hold_v_ff && (em_en || flush)) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         if (advance && em_en) hold_v_ff <= 1'b1;
         else if (advance && flush) hold_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         buf_ff <= buf_in;
         key_ff <= key_in;
         sec_ff <= sec_in;
      end
      if (advance && hold_v_ff && (em_en || flush)) begin
         out_ff <= '{rk: hold_ff.rk, val: hold_ff.val, kind: hold_ff.kind,
                     line: hold_ff.line, col: hold_ff.col, last: flush};
      end
      if (advance && em_en) begin
         hold_ff <= '{rk: em.rk, val: (em.rk == RK_TOKEN) ? 8'd0 : em.val,
                      kind: (em.rk == RK_TOKEN) ? em.kind : K_EOF,
                      line: 16'(em_line), col: 16'(em_col), last: 1'b0};
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_record_kind = out_ff.rk;
   assign rsp_value_char  = out_ff.val;
   assign rsp_token_kind  = out_ff.kind;
   assign rsp_start_line  = out_ff.line;
   assign rsp_start_col   = out_ff.col;
   assign rsp_last_of_run = out_ff.last;

   `PLT_ASSERT(a_fill_max, fill_ff <= FILL_BITS'(LOOKAHEAD))
   `PLT_ASSERT(a_wlen_max, wlen_ff <= WLEN_BITS'(MATCH_LEN + 1))
   `PLT_ASSERT(a_wait_flushed, (seq_ff == S_WAIT) |-> !hold_v_ff)
   `PLT_ASSERT_NEXT(a_indent_full, advance && seq_ff == S_DRAIN && seq_in == S_INDENT, fill_ff >= FILL_BITS'(4))

endmodule

// ===== src/proof_language_tokenizer.sv =====
// results: each record waits in a hold register and goes out once the next record is made
//   or the run ends; lookahead and end-mark steps that give no result delay the first one
// a new request is taken once the steps of the last are through; a delimiter token or odd
//   escape adds a second record, an indent and an end mark add steps; rsp_stall holds them
// the front queue holds 2 requests, so up to 2 requests are taken while results wait
// reset: synchronous, active high; counters to line 1 column 1, queue and lookahead empty
module proof_language_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_input,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_record_kind,
   output logic [7:0]  rsp_value_char,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_col,
   output logic        rsp_last_of_run
);
   import ptok_pkg::*;

   // head of the request queue, seen by the sequencer
   queue_head_type head;
   logic           head_pop;

   // front: takes requests, marks the end of source, queues them
   ptok_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .head             (head),
      .head_pop         (head_pop)
   );

   // back: lookahead window, scanner modes, keyword match, result staging
   ptok_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_pop        (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_record_kind (rsp_record_kind),
      .rsp_value_char  (rsp_value_char),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_start_line  (rsp_start_line),
      .rsp_start_col   (rsp_start_col),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
